// ===== hdl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg - shared types and constants for the escape-time unit
// Holds the sequencer states, the step control bundle that the sequencer
// hands to the update cell, and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package mbet_pkg;

    // Fixed widths of the register and result fields
    localparam int CFG_WIDTH = 10;
    localparam int OUT_WIDTH = 10;

    // Iteration limit after reset
    localparam logic [CFG_WIDTH-1:0] MAX_ITER_RESET = 10'd100;

    // Working registers carry this many integer bits beyond the input format
    localparam int EXTRA_INT_BITS = 4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_DONE
    } mbet_state_t;

    // Control from the sequencer to the update cell
    typedef struct packed {
        logic init;     // load z = 0 for a new point
        logic commit;   // take the new z computed from the products
    } mbet_step_ctrl_t;

endpackage

// ===== hdl/mbet_square_cell.sv =====
// ----------------------------------------------------------------------------
// mbet_square_cell - product cell of the iteration ring
// Registers zr^2, zi^2 and zr*zi at full precision, together with a flag
// that is set when either component of z lies beyond +/-2.0.
// ----------------------------------------------------------------------------
module mbet_square_cell #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                                              clk,
    input  logic                                              en,
    input  logic signed [COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS-1:0]     zr,
    input  logic signed [COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS-1:0]     zi,
    output logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] rr,
    output logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] ii,
    output logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] ri,
    output logic                                              big
);

    localparam int ZW = COORD_WIDTH + mbet_pkg::EXTRA_INT_BITS;
    localparam int PW = 2 * ZW;

    localparam logic signed [ZW-1:0] TWO     = ZW'(2) << FRAC_BITS;
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;

    logic signed [PW-1:0] rr_reg, rr_next;
    logic signed [PW-1:0] ii_reg, ii_next;
    logic signed [PW-1:0] ri_reg, ri_next;
    logic                 big_reg, big_next;

    // Three products in parallel, plus the component range check
    always_comb
    begin
        rr_next  = zr * zr;
        ii_next  = zi * zi;
        ri_next  = zr * zi;
        big_next = (zr > TWO) || (zr < NEG_TWO) || (zi > TWO) || (zi < NEG_TWO);
    end

    // Product registers, loaded once per iteration
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg  <= rr_next;
            ii_reg  <= ii_next;
            ri_reg  <= ri_next;
            big_reg <= big_next;
        end
    end

    assign rr  = rr_reg;
    assign ii  = ii_reg;
    assign ri  = ri_reg;
    assign big = big_reg;

endmodule

// ===== hdl/mbet_update_cell.sv =====
// ----------------------------------------------------------------------------
// mbet_update_cell - update cell of the iteration ring
// Holds z. From the registered products it makes the escape decision
// (|z|^2 > 4.0, or the big flag) and the next z = z^2 + c, taken on commit.
// ----------------------------------------------------------------------------
module mbet_update_cell #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                                              clk,
    input  mbet_pkg::mbet_step_ctrl_t                         ctrl,
    input  logic signed [COORD_WIDTH-1:0]                     c_real,
    input  logic signed [COORD_WIDTH-1:0]                     c_imag,
    input  logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] rr,
    input  logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] ii,
    input  logic signed [2*(COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS)-1:0] ri,
    input  logic                                              big,
    output logic signed [COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS-1:0]     zr,
    output logic signed [COORD_WIDTH+mbet_pkg::EXTRA_INT_BITS-1:0]     zi,
    output logic                                              escape
);

    localparam int XB = mbet_pkg::EXTRA_INT_BITS;
    localparam int ZW = COORD_WIDTH + XB;
    localparam int PW = 2 * ZW;
    localparam int SW = PW + 1;

    // 4.0 at twice the fraction bits
    localparam logic signed [SW-1:0] FOUR_SQ = SW'(4) << (2 * FRAC_BITS);

    logic signed [ZW-1:0] zr_reg, zr_next;
    logic signed [ZW-1:0] zi_reg, zi_next;

    logic signed [SW-1:0] rr_x, ii_x;
    logic signed [SW-1:0] mag_sq;
    logic signed [SW-1:0] re_full, im_full;
    logic signed [SW-1:0] re_shift, im_shift;
    logic signed [ZW-1:0] cr_x, ci_x;

    // Escape test and next z
    always_comb
    begin
        rr_x     = {rr[PW-1], rr};
        ii_x     = {ii[PW-1], ii};
        mag_sq   = rr_x + ii_x;
        escape   = big || (mag_sq > FOUR_SQ);
        re_full  = rr_x - ii_x;
        im_full  = {ri, 1'b0};
        // arithmetic shift floors toward minus infinity
        re_shift = re_full >>> FRAC_BITS;
        im_shift = im_full >>> FRAC_BITS;
        cr_x     = {{XB{c_real[COORD_WIDTH-1]}}, c_real};
        ci_x     = {{XB{c_imag[COORD_WIDTH-1]}}, c_imag};
        zr_next  = re_shift[ZW-1:0] + cr_x;
        zi_next  = im_shift[ZW-1:0] + ci_x;
    end

    // z registers
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
    end

    assign zr = zr_reg;
    assign zi = zi_reg;

endmodule

// ===== hdl/mandelbrot_escape_time_unit.sv =====
// ----------------------------------------------------------------------------
// Point c enters as signed fixed point; the unit iterates z = z^2 + c from
// z = 0 and returns how many steps ran before |z|^2 exceeded 4.0, or the
// iteration limit if it never did. One point is in flight at a time. Each
// step passes through the product cell and then the update cell. The
// result sits in an output register, so the next point may enter while
// it waits. A limit of 0 reports 0.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit - escape-time iteration unit
// Sequencer, limit register, output register and the two-cell ring.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 12,
    parameter int COUNT_WIDTH = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // point channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        c_real,
    input  logic signed [COORD_WIDTH-1:0]        c_imag,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mbet_pkg::OUT_WIDTH-1:0]       iteration_count,
    // limit register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbet_pkg::CFG_WIDTH-1:0]       max_iterations
);

    localparam int ZW = COORD_WIDTH + mbet_pkg::EXTRA_INT_BITS;
    localparam int PW = 2 * ZW;

    mbet_pkg::mbet_state_t state_reg, state_next;

    logic [mbet_pkg::CFG_WIDTH-1:0] max_iter_reg;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic [COUNT_WIDTH-1:0]         limit;
    logic signed [COORD_WIDTH-1:0]  cr_reg, ci_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [mbet_pkg::OUT_WIDTH-1:0] count_out_reg, count_out_next;

    mbet_pkg::mbet_step_ctrl_t      ctrl;
    logic                           sq_en;
    logic                           in_beat;
    logic                           out_beat;
    logic                           load_out;

    logic signed [ZW-1:0]           zr, zi;
    logic signed [PW-1:0]           rr, ii, ri;
    logic                           big;
    logic                           escape;

    assign limit    = COUNT_WIDTH'(max_iter_reg);
    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid_reg && out_ready;

    // Limit register; writes must only arrive while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mbet_pkg::MAX_ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_iter_reg <= max_iterations;
        end
    end

    // Point register
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
        end
    end

    // Sequencer state, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbet_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_out_reg <= count_out_next;
    end

    // Next state and step control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        in_ready       = 1'b0;
        sq_en          = 1'b0;
        ctrl.init      = 1'b0;
        ctrl.commit    = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.init  = 1'b1;
                    count_next = '0;
                    state_next = mbet_pkg::ST_SQUARE;
                end
            end
            mbet_pkg::ST_SQUARE:
            begin
                if (count_reg >= limit)
                begin
                    state_next = mbet_pkg::ST_DONE;
                end
                else
                begin
                    sq_en      = 1'b1;
                    state_next = mbet_pkg::ST_UPDATE;
                end
            end
            mbet_pkg::ST_UPDATE:
            begin
                if (escape)
                begin
                    state_next = mbet_pkg::ST_DONE;
                end
                else
                begin
                    ctrl.commit = 1'b1;
                    count_next  = count_reg + 1'b1;
                    state_next  = mbet_pkg::ST_SQUARE;
                end
            end
            mbet_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = mbet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbet_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished count, drop on a taken beat
    always_comb
    begin
        count_out_next = count_out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            count_out_next = mbet_pkg::OUT_WIDTH'(count_reg);
            out_valid_next = 1'b1;
        end
        else if (out_beat)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_out_reg;

    // Iteration ring: product cell feeds update cell, update cell feeds back z
    mbet_square_cell #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_square (
        .clk (clk),
        .en  (sq_en),
        .zr  (zr),
        .zi  (zi),
        .rr  (rr),
        .ii  (ii),
        .ri  (ri),
        .big (big)
    );

    mbet_update_cell #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_update (
        .clk    (clk),
        .ctrl   (ctrl),
        .c_real (cr_reg),
        .c_imag (ci_reg),
        .rr     (rr),
        .ii     (ii),
        .ri     (ri),
        .big    (big),
        .zr     (zr),
        .zi     (zi),
        .escape (escape)
    );

    // A step is only evaluated while the count is below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbet_pkg::ST_UPDATE) |-> (count_reg < limit))
        else $error("update step entered with count at or above limit");

    // A new point starts from a zero count in the product step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> ((state_reg == mbet_pkg::ST_SQUARE) && (count_reg == '0)))
        else $error("new point did not start from a cleared count");

    // A committed step advances the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("committed step did not advance the count");

    // A finished point lands in the output register with its count
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg &&
                      (count_out_reg == mbet_pkg::OUT_WIDTH'($past(count_reg)))))
        else $error("finished count not presented on the result channel");

    // Results are only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (state_reg == mbet_pkg::ST_DONE))
        else $error("result loaded outside the done state");

endmodule

// ===== tb/tb_mandelbrot_escape_time_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_unit - self-checking bench for the escape-time unit
// Sends complex points into the unit and checks every returned iteration
// count against a hand count from the table or an escape-time calculation in
// the bench. A short table of corner points comes first, then random points
// in several limit phases, from a zero limit up to the largest. Both channels
// idle at random, and the result side holds off once for a long stretch so that the unit fills up.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_unit;

    localparam int COORD_W = 16;
    localparam int FRAC_W  = 12;
    localparam int WORK_W  = COORD_W + mbet_pkg::EXTRA_INT_BITS;
    localparam int PROD_W  = 2 * WORK_W + 1;

    // 2.0 at the working format, 4.0 at the product format
    localparam logic signed [WORK_W-1:0] Z_TWO   = 20'sd8192;
    localparam logic signed [PROD_W-1:0] ABS2_MAX = 41'sd67108864;

    localparam int N_CORNERS = 22;
    localparam int N_PHASES  = 7;
    localparam int HOLD_AT   = 40;     // results seen before the long hold
    localparam int HOLD_LEN  = 400;    // length of the long hold

    typedef struct packed {
        logic signed [COORD_W-1:0]       re;
        logic signed [COORD_W-1:0]       im;
        bit                              typed;   // count below is known by hand
        logic [mbet_pkg::OUT_WIDTH-1:0]  count;
    } corner_row_t;

    typedef enum int {
        RX_STEADY,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    // Corner points, run at the limit after reset
    corner_row_t corner_rows [N_CORNERS] = '{
        '{16'sd0,      16'sd0,      1'b1, 10'd100},   // origin never escapes
        '{16'sh8000,   16'sh8000,   1'b1, 10'd1},     // most negative corner
        '{16'sh7fff,   16'sh7fff,   1'b1, 10'd1},     // most positive corner
        '{16'sh8000,   16'sh7fff,   1'b1, 10'd1},
        '{16'sh7fff,   16'sh8000,   1'b1, 10'd1},
        '{16'sd8192,   16'sd0,      1'b1, 10'd2},     // c = 2.0 on the edge
        '{16'sd8193,   16'sd0,      1'b1, 10'd1},     // just past 2.0
        '{-16'sd8192,  16'sd0,      1'b1, 10'd100},   // c = -2 sits at 2
        '{16'sd0,      16'sd8192,   1'b1, 10'd2},
        '{16'sd0,      -16'sd8192,  1'b1, 10'd2},
        '{-16'sd4096,  16'sd0,      1'b1, 10'd100},   // c = -1 swings between 0 and -1
        '{16'sd0,      16'sd4096,   1'b1, 10'd100},   // c = i stays bounded
        '{16'sd5793,   16'sd5793,   1'b1, 10'd1},     // |c|^2 just above 4
        '{16'sd5792,   16'sd5792,   1'b1, 10'd2},     // |c|^2 just below 4
        '{16'sh5555,   16'shaaaa,   1'b1, 10'd1},
        '{16'shaaaa,   16'sh5555,   1'b1, 10'd1},
        '{-16'sd1,     -16'sd1,     1'b0, 10'd0},
        '{-16'sd3072,  16'sd2600,   1'b0, 10'd0},
        '{16'sd1500,   -16'sd300,   1'b0, 10'd0},
        '{-16'sd7000,  16'sd500,    1'b0, 10'd0},
        '{16'sd1000,   16'sd2400,   1'b0, 10'd0},
        '{-16'sd6000,  16'sd0,      1'b0, 10'd0}
    };

    // Limit per phase (-1 picks one at random) and random points per phase
    int phase_limit [N_PHASES] = '{100, 0, 1, 1023, 2, 255, -1};
    int phase_items [N_PHASES] = '{200, 60, 60, 30, 60, 150, 180};

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [COORD_W-1:0]           c_real;
    logic signed [COORD_W-1:0]           c_imag;
    logic                                out_valid;
    logic                                out_ready;
    logic [mbet_pkg::OUT_WIDTH-1:0]      iteration_count;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [mbet_pkg::CFG_WIDTH-1:0]      max_iterations;

    logic [mbet_pkg::CFG_WIDTH-1:0]      iter_limit;      // bench copy of the register
    logic [mbet_pkg::OUT_WIDTH-1:0]      expected_counts[$];
    logic [mbet_pkg::OUT_WIDTH-1:0]      want_count;
    int                                  error_count = 0;
    int                                  results_seen = 0;
    int                                  burst_left;

    mandelbrot_escape_time_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_iterations  (max_iterations)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Escape-time count of point c under the given limit
    function automatic logic [mbet_pkg::OUT_WIDTH-1:0] escape_count(
        input logic signed [COORD_W-1:0]     cr,
        input logic signed [COORD_W-1:0]     ci,
        input logic [mbet_pkg::CFG_WIDTH-1:0] limit
    );
        logic signed [WORK_W-1:0] zr;
        logic signed [WORK_W-1:0] zi;
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri2;
        logic signed [PROD_W-1:0] re_next;
        logic signed [PROD_W-1:0] im_next;
        logic [mbet_pkg::OUT_WIDTH-1:0] n;
        bit                       escaped;
        zr = '0;
        zi = '0;
        n = '0;
        escaped = 1'b0;
        while (!escaped && n < limit)
        begin
            // a component beyond 2.0 escapes without the full test
            if (zr > Z_TWO || zr < -Z_TWO || zi > Z_TWO || zi < -Z_TWO)
                escaped = 1'b1;
            else
            begin
                rr = zr * zr;
                ii = zi * zi;
                if (rr + ii > ABS2_MAX)
                    escaped = 1'b1;
                else
                begin
                    ri2 = (zr * zi) <<< 1;
                    re_next = (rr - ii) >>> FRAC_W;
                    im_next = ri2 >>> FRAC_W;
                    zr = $signed(re_next[WORK_W-1:0]) + cr;
                    zi = $signed(im_next[WORK_W-1:0]) + ci;
                    n = n + 1'b1;
                end
            end
        end
        return n;
    endfunction

    // Random point, weighted toward the region where escape takes a while
    task automatic pick_point(output logic signed [COORD_W-1:0] re,
                              output logic signed [COORD_W-1:0] im);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            re = COORD_W'(int'($urandom_range(0, 12011)) - 9011);
            im = COORD_W'(int'($urandom_range(0, 12288)) - 6144);
        end
        else if (sel < 70)
        begin
            re = COORD_W'(int'($urandom_range(0, 3000)) - 2000);
            im = COORD_W'(int'($urandom_range(0, 3000)) - 1500);
        end
        else if (sel < 85)
        begin
            // close to the 2.0 box edge
            re = COORD_W'(int'($urandom_range(8186, 8198)));
            if ($urandom_range(0, 1))
                re = -re;
            im = COORD_W'(int'($urandom_range(0, 12)) - 6);
            if ($urandom_range(0, 1))
            begin
                im = re;
                re = COORD_W'(int'($urandom_range(0, 600)) - 300);
            end
        end
        else
        begin
            re = COORD_W'($urandom);
            im = COORD_W'($urandom);
        end
    endtask

    // Offer one point and queue its count once the beat is taken
    task automatic offer_point(input logic signed [COORD_W-1:0]    re,
                               input logic signed [COORD_W-1:0]    im,
                               input bit                           typed,
                               input logic [mbet_pkg::OUT_WIDTH-1:0] typed_count);
        @(negedge clk);
        in_valid <= 1'b1;
        c_real   <= re;
        c_imag   <= im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            expected_counts.push_back(typed_count);
        else
            expected_counts.push_back(escape_count(re, im, iter_limit));
    endtask

    // Sender pacing: bursts of beats with idle gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic write_limit(input logic [mbet_pkg::CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid      <= 1'b1;
        max_iterations <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        iter_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: corner table, then random phases at several limits
    initial
    begin
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
        int                        lim;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        c_real         = '0;
        c_imag         = '0;
        cfg_valid      = 1'b0;
        max_iterations = '0;
        iter_limit     = mbet_pkg::MAX_ITER_RESET;
        burst_left     = $urandom_range(1, 16);
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_CORNERS; r++)
        begin
            offer_point(corner_rows[r].re, corner_rows[r].im,
                        corner_rows[r].typed, corner_rows[r].count);
            pace_sender();
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain_results();
                lim = phase_limit[p];
                if (lim < 0)
                    lim = $urandom_range(3, 400);
                write_limit(lim[mbet_pkg::CFG_WIDTH-1:0]);
            end
            for (int k = 0; k < phase_items[p]; k++)
            begin
                pick_point(re, im);
                offer_point(re, im, 1'b0, '0);
                pace_sender();
            end
        end

        drain_results();
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("tb_mandelbrot_escape_time_unit: clean");
        else
            $display("tb_mandelbrot_escape_time_unit: errors");
        $finish;
    end

    // Result side: changing stall patterns, plus one long hold
    initial
    begin
        rx_mode_t mode;
        int       run_len;
        bit       held;
        out_ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                repeat (HOLD_LEN)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            run_len = $urandom_range(8, 64);
            repeat (run_len)
            begin
                @(negedge clk);
                unique case (mode)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Compare each result beat with the oldest queued count
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_counts.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, count %0d",
                         $time, iteration_count);
            end
            else
            begin
                want_count = expected_counts.pop_front();
                if (iteration_count !== want_count)
                begin
                    error_count++;
                    $display("%0t: iteration_count expected %0d, got %0d",
                             $time, want_count, iteration_count);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #30000000;
        $display("tb_mandelbrot_escape_time_unit: errors");
        $finish;
    end

endmodule
